/* hdl/bpist_pkg.sv */
// Shared types, register map and reset values for the button press and idle sleep timer.
package bpist_pkg;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DEBOUNCE      = 3'd0;
  localparam logic [2:0] REG_SHORT_MIN     = 3'd1;
  localparam logic [2:0] REG_SHORT_MAX     = 3'd2;
  localparam logic [2:0] REG_LONG_MIN      = 3'd3;
  localparam logic [2:0] REG_CHECK_INTRVL  = 3'd4;
  localparam logic [2:0] REG_SLEEP_TIMEOUT = 3'd5;
  localparam logic [2:0] REG_SLEEP_ENABLE  = 3'd6;

  localparam logic [15:0] RST_DEBOUNCE      = 16'd50;
  localparam logic [15:0] RST_SHORT_MIN     = 16'd50;
  localparam logic [15:0] RST_SHORT_MAX     = 16'd1000;
  localparam logic [15:0] RST_LONG_MIN      = 16'd3000;
  localparam logic [15:0] RST_CHECK_INTRVL  = 16'd1000;
  localparam logic [31:0] RST_SLEEP_TIMEOUT = 32'd300000;
  localparam logic        RST_SLEEP_ENABLE  = 1'b1;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] short_min_ms;
    logic [15:0] short_max_ms;
    logic [15:0] long_min_ms;
    logic [15:0] check_interval_ms;
    logic [31:0] sleep_timeout_ms;
    logic        sleep_enable;
  } cfg_t;

  typedef struct packed {
    logic button_down;
    logic board_power_on;
    logic link_connected;
    logic activity;
  } tick_t;

  typedef struct packed {
    logic        short_press;
    logic        long_press;
    logic        sleep_request;
    logic [31:0] time_until_sleep;
    logic        button_held;
  } res_t;

endpackage

/* hdl/button_press_and_idle_sleep_timer.sv */
// Top level: input word register, tick core, result register and config registers.
//
//   channel | direction | handshake            | payload
//   in_     | in        | in_valid / in_ready  | button_down, board_power_on, link_connected,
//           |           |                      | activity (one word per millisecond tick)
//   out_    | out       | out_valid / out_ready| short_press, long_press, sleep_request,
//           |           |                      | time_until_sleep, button_held
//   cfg     | in        | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One word per cycle sustained while out_ready stays high; a taken word is held in the input
// register, then passes through the tick core into the result register.
// Reset (rst_n low, synchronous) empties both registers and clears all counters.
// While out_ready is low the result register holds and the input register takes one
// more word; in_ready then drops until the result register drains.
module button_press_and_idle_sleep_timer #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_button_down,
  input  logic                            in_board_power_on,
  input  logic                            in_link_connected,
  input  logic                            in_activity,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_short_press,
  output logic                            out_long_press,
  output logic                            out_sleep_request,
  output logic [31:0]                     out_time_until_sleep,
  output logic                            out_button_held,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpist_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bpist_pkg::DATA_BITS-1:0] pwdata,
  output logic [bpist_pkg::DATA_BITS-1:0] prdata,
  output logic                            pready
);

  bpist_pkg::cfg_t  cfg;
  bpist_pkg::tick_t tick_r;
  bpist_pkg::res_t  res, res_r;
  logic             word_valid_r, out_valid_r;
  logic             in_take, step_go;

  assign step_go  = word_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !word_valid_r || step_go;
  assign in_take  = in_valid && in_ready;

  bpist_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpist_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_go),
    .tick    (tick_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) begin
        word_valid_r <= 1'b1;
      end else if (step_go) begin
        word_valid_r <= 1'b0;
      end
      if (step_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_r.button_down    <= in_button_down;
      tick_r.board_power_on <= in_board_power_on;
      tick_r.link_connected <= in_link_connected;
      tick_r.activity       <= in_activity;
    end
    if (step_go) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_short_press      = res_r.short_press;
  assign out_long_press       = res_r.long_press;
  assign out_sleep_request    = res_r.sleep_request;
  assign out_time_until_sleep = res_r.time_until_sleep;
  assign out_button_held      = res_r.button_held;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !step_go)
    else $error("result register overwritten while stalled");

  a_word_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |=> out_valid_r)
    else $error("stepped word produced no result");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    word_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken with both registers full");

endmodule

/* hdl/bpist_cfg.sv */
// APB-style register file holding the timer thresholds and the sleep enable.
module bpist_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpist_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bpist_pkg::DATA_BITS-1:0] pwdata,
  output logic [bpist_pkg::DATA_BITS-1:0] prdata,
  output logic                            pready,
  output bpist_pkg::cfg_t                 cfg
);

  bpist_pkg::cfg_t cfg_r;
  logic [2:0]      idx;
  logic            wr_en;

  assign idx    = paddr[bpist_pkg::ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms       <= bpist_pkg::RST_DEBOUNCE;
      cfg_r.short_min_ms      <= bpist_pkg::RST_SHORT_MIN;
      cfg_r.short_max_ms      <= bpist_pkg::RST_SHORT_MAX;
      cfg_r.long_min_ms       <= bpist_pkg::RST_LONG_MIN;
      cfg_r.check_interval_ms <= bpist_pkg::RST_CHECK_INTRVL;
      cfg_r.sleep_timeout_ms  <= bpist_pkg::RST_SLEEP_TIMEOUT;
      cfg_r.sleep_enable      <= bpist_pkg::RST_SLEEP_ENABLE;
    end else if (wr_en) begin
      case (idx)
        bpist_pkg::REG_DEBOUNCE:      cfg_r.debounce_ms       <= pwdata[15:0];
        bpist_pkg::REG_SHORT_MIN:     cfg_r.short_min_ms      <= pwdata[15:0];
        bpist_pkg::REG_SHORT_MAX:     cfg_r.short_max_ms      <= pwdata[15:0];
        bpist_pkg::REG_LONG_MIN:      cfg_r.long_min_ms       <= pwdata[15:0];
        bpist_pkg::REG_CHECK_INTRVL:  cfg_r.check_interval_ms <= pwdata[15:0];
        bpist_pkg::REG_SLEEP_TIMEOUT: cfg_r.sleep_timeout_ms  <= pwdata[31:0];
        bpist_pkg::REG_SLEEP_ENABLE:  cfg_r.sleep_enable      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bpist_pkg::REG_DEBOUNCE:      prdata = {16'd0, cfg_r.debounce_ms};
      bpist_pkg::REG_SHORT_MIN:     prdata = {16'd0, cfg_r.short_min_ms};
      bpist_pkg::REG_SHORT_MAX:     prdata = {16'd0, cfg_r.short_max_ms};
      bpist_pkg::REG_LONG_MIN:      prdata = {16'd0, cfg_r.long_min_ms};
      bpist_pkg::REG_CHECK_INTRVL:  prdata = {16'd0, cfg_r.check_interval_ms};
      bpist_pkg::REG_SLEEP_TIMEOUT: prdata = cfg_r.sleep_timeout_ms;
      bpist_pkg::REG_SLEEP_ENABLE:  prdata = {31'd0, cfg_r.sleep_enable};
      default:                      prdata = '0;
    endcase
  end

endmodule

/* hdl/bpist_core.sv */
// Per-tick state update: debounce, press classification and idle sleep watchdog.
module bpist_core #(
  parameter int TIME_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  bpist_pkg::tick_t tick,
  input  bpist_pkg::cfg_t  cfg,
  output bpist_pkg::res_t  res
);

  localparam logic [TIME_BITS-1:0] TMAX     = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] TICK_ONE = TIME_BITS'(1);

  logic                 stable_level_r, stable_level_nxt;
  logic                 press_active_r, press_active_nxt;
  logic [TIME_BITS-1:0] since_edge_r, since_edge_nxt;
  logic [TIME_BITS-1:0] press_length_r, press_length_nxt;
  logic [TIME_BITS-1:0] idle_time_r, idle_time_nxt;
  logic [TIME_BITS-1:0] since_check_r, since_check_nxt;

  logic [TIME_BITS-1:0] se_inc, pl_inc, it_inc, sc_inc;
  logic [31:0]          pl_w, it_w;
  logic                 edge_ok, check_due, blocked_n;

  assign se_inc = (since_edge_r   == TMAX) ? TMAX : since_edge_r   + TICK_ONE;
  assign pl_inc = (press_length_r == TMAX) ? TMAX : press_length_r + TICK_ONE;
  assign it_inc = (idle_time_r    == TMAX) ? TMAX : idle_time_r    + TICK_ONE;
  assign sc_inc = (since_check_r  == TMAX) ? TMAX : since_check_r  + TICK_ONE;

  assign pl_w      = 32'(pl_inc);
  assign edge_ok   = (tick.button_down != stable_level_r) &&
                     (32'(se_inc) > 32'(cfg.debounce_ms));
  assign check_due = 32'(sc_inc) >= 32'(cfg.check_interval_ms);
  assign blocked_n = !tick.board_power_on && !tick.link_connected;

  always_comb begin
    stable_level_nxt = stable_level_r;
    press_active_nxt = press_active_r;
    since_edge_nxt   = se_inc;
    press_length_nxt = pl_inc;
    idle_time_nxt    = tick.activity ? '0 : it_inc;
    since_check_nxt  = sc_inc;
    res              = '0;

    if (edge_ok) begin
      stable_level_nxt = tick.button_down;
      since_edge_nxt   = '0;
      if (tick.button_down) begin
        press_active_nxt = 1'b1;
        press_length_nxt = '0;
        idle_time_nxt    = '0;
      end else if (press_active_r) begin
        press_active_nxt = 1'b0;
        // short range wins where it overlaps the long threshold
        if (pl_w >= 32'(cfg.short_min_ms) && pl_w <= 32'(cfg.short_max_ms)) begin
          res.short_press = 1'b1;
        end else if (pl_w >= 32'(cfg.long_min_ms)) begin
          res.long_press = 1'b1;
        end
      end
    end

    if (check_due) begin
      since_check_nxt = '0;
      if (cfg.sleep_enable) begin
        if (blocked_n) begin
          // request repeats each check; idle timer is left running
          res.sleep_request = 32'(idle_time_nxt) >= cfg.sleep_timeout_ms;
        end else begin
          idle_time_nxt = '0;
        end
      end
    end

    it_w = 32'(idle_time_nxt);
    if (cfg.sleep_enable && blocked_n && it_w < cfg.sleep_timeout_ms) begin
      res.time_until_sleep = cfg.sleep_timeout_ms - it_w;
    end
    res.button_held = press_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_level_r <= 1'b0;
      press_active_r <= 1'b0;
      since_edge_r   <= '0;
      press_length_r <= '0;
      idle_time_r    <= '0;
      since_check_r  <= '0;
    end else if (step_en) begin
      stable_level_r <= stable_level_nxt;
      press_active_r <= press_active_nxt;
      since_edge_r   <= since_edge_nxt;
      press_length_r <= press_length_nxt;
      idle_time_r    <= idle_time_nxt;
      since_check_r  <= since_check_nxt;
    end
  end

  a_one_class: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> !(res.short_press && res.long_press))
    else $error("short and long press in one tick");

  a_release_drops_held: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (res.short_press || res.long_press) |=> !press_active_r)
    else $error("press still active after classified release");

  a_due_has_no_time_left: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.sleep_request |-> res.time_until_sleep == 32'd0)
    else $error("sleep requested with time left");

endmodule

/* sim/testbench.sv */
// Testbench for the button press and idle sleep timer: directed and random ticks with checking.
module testbench;

  localparam int CLK_HALF = 2;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef enum logic [1:0] {DRAIN_FREE, DRAIN_RANDOM, DRAIN_PATTERN} drain_style_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_button_down;
  logic                            in_board_power_on;
  logic                            in_link_connected;
  logic                            in_activity;
  logic                            out_valid;
  logic                            out_ready;
  logic                            out_short_press;
  logic                            out_long_press;
  logic                            out_sleep_request;
  logic [31:0]                     out_time_until_sleep;
  logic                            out_button_held;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [bpist_pkg::ADDR_BITS-1:0] paddr;
  logic [bpist_pkg::DATA_BITS-1:0] pwdata;
  logic [bpist_pkg::DATA_BITS-1:0] prdata;
  logic                            pready;

  button_press_and_idle_sleep_timer uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_button_down       (in_button_down),
    .in_board_power_on    (in_board_power_on),
    .in_link_connected    (in_link_connected),
    .in_activity          (in_activity),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_short_press      (out_short_press),
    .out_long_press       (out_long_press),
    .out_sleep_request    (out_sleep_request),
    .out_time_until_sleep (out_time_until_sleep),
    .out_button_held      (out_button_held),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // Timer shadow: registers and counters as the block should hold them
  bpist_pkg::cfg_t cfg_now;
  logic            stable_lvl;
  logic            held;
  logic [31:0]     since_edge;
  logic [31:0]     press_len;
  logic [31:0]     idle_ms;
  logic [31:0]     since_chk;

  bpist_pkg::res_t owed_results[$];
  int              mismatches;

  // Sender and receiver pacing
  bit           gaps_on;
  int           burst_left;
  drain_style_t drain_style;
  int           hold_off;
  logic [7:0]   drain_mask;
  logic [7:0]   rx_phase;

  // Random traffic shape
  logic btn_now;
  logic pwr_now;
  logic link_now;
  int   seg_left;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [31:0] sat_up(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void clear_timer();
    cfg_now.debounce_ms       = bpist_pkg::RST_DEBOUNCE;
    cfg_now.short_min_ms      = bpist_pkg::RST_SHORT_MIN;
    cfg_now.short_max_ms      = bpist_pkg::RST_SHORT_MAX;
    cfg_now.long_min_ms       = bpist_pkg::RST_LONG_MIN;
    cfg_now.check_interval_ms = bpist_pkg::RST_CHECK_INTRVL;
    cfg_now.sleep_timeout_ms  = bpist_pkg::RST_SLEEP_TIMEOUT;
    cfg_now.sleep_enable      = bpist_pkg::RST_SLEEP_ENABLE;
    stable_lvl = 1'b0;
    held       = 1'b0;
    since_edge = '0;
    press_len  = '0;
    idle_ms    = '0;
    since_chk  = '0;
  endfunction

  // Advance the shadow by one millisecond tick and return what the block should report
  function automatic bpist_pkg::res_t timer_tick(input bpist_pkg::tick_t t);
    bpist_pkg::res_t r;
    r = '0;
    since_edge = sat_up(since_edge);
    press_len  = sat_up(press_len);
    idle_ms    = sat_up(idle_ms);
    since_chk  = sat_up(since_chk);
    if (t.activity) idle_ms = '0;
    if (t.button_down != stable_lvl && since_edge > 32'(cfg_now.debounce_ms)) begin
      stable_lvl = t.button_down;
      since_edge = '0;
      if (t.button_down) begin
        held      = 1'b1;
        press_len = '0;
        idle_ms   = '0;
      end else if (held) begin
        held = 1'b0;
        // short range wins where it overlaps the long one
        if (press_len >= 32'(cfg_now.short_min_ms) && press_len <= 32'(cfg_now.short_max_ms))
          r.short_press = 1'b1;
        else if (press_len >= 32'(cfg_now.long_min_ms))
          r.long_press = 1'b1;
      end
    end
    if (since_chk >= 32'(cfg_now.check_interval_ms)) begin
      since_chk = '0;
      if (cfg_now.sleep_enable) begin
        if (!t.board_power_on && !t.link_connected) begin
          if (idle_ms >= cfg_now.sleep_timeout_ms) r.sleep_request = 1'b1;
        end else begin
          idle_ms = '0;
        end
      end
    end
    if (cfg_now.sleep_enable && !t.board_power_on && !t.link_connected &&
        idle_ms < cfg_now.sleep_timeout_ms)
      r.time_until_sleep = cfg_now.sleep_timeout_ms - idle_ms;
    r.button_held = held;
    return r;
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    case (idx)
      bpist_pkg::REG_DEBOUNCE:      return 32'(cfg_now.debounce_ms);
      bpist_pkg::REG_SHORT_MIN:     return 32'(cfg_now.short_min_ms);
      bpist_pkg::REG_SHORT_MAX:     return 32'(cfg_now.short_max_ms);
      bpist_pkg::REG_LONG_MIN:      return 32'(cfg_now.long_min_ms);
      bpist_pkg::REG_CHECK_INTRVL:  return 32'(cfg_now.check_interval_ms);
      bpist_pkg::REG_SLEEP_TIMEOUT: return cfg_now.sleep_timeout_ms;
      default:                      return 32'(cfg_now.sleep_enable);
    endcase
  endfunction

  task automatic log_mismatch(input string why, input bpist_pkg::res_t want,
                              input bpist_pkg::res_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): expected sp=%0b lp=%0b sr=%0b left=%0d held=%0b, ",
                "got sp=%0b lp=%0b sr=%0b left=%0d held=%0b"},
               why, want.short_press, want.long_press, want.sleep_request,
               want.time_until_sleep, want.button_held, seen.short_press, seen.long_press,
               seen.sleep_request, seen.time_until_sleep, seen.button_held);
  endtask

  // Result checker: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    bpist_pkg::res_t seen;
    bpist_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_short_press, out_long_press, out_sleep_request, out_time_until_sleep,
              out_button_held};
      if (owed_results.size() == 0) begin
        log_mismatch("no result owed", '0, seen);
      end else begin
        want = owed_results.pop_front();
        if (seen.short_press !== want.short_press || seen.long_press !== want.long_press ||
            seen.sleep_request !== want.sleep_request ||
            seen.time_until_sleep !== want.time_until_sleep ||
            seen.button_held !== want.button_held)
          log_mismatch("field", want, seen);
      end
    end
  end

  // Receiver: long hold-off when asked, otherwise the current stall style
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_phase++;
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else begin
        case (drain_style)
          DRAIN_FREE:   out_ready <= 1'b1;
          DRAIN_RANDOM: out_ready <= ($urandom_range(0, 99) >= 35);
          default:      out_ready <= drain_mask[rx_phase[2:0]];
        endcase
      end
    end
  end

  task automatic apb_read_check(input logic [2:0] idx);
    logic [31:0] want;
    want = reg_value(idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want || pready !== 1'b1) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: register %0d read %h ready %b, expected %h ready 1",
                 idx, prdata, pready, want);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write one register with junk in the bits it ignores, then read it back unless it is unmapped
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] word;
    word = value;
    if (idx != bpist_pkg::REG_SLEEP_TIMEOUT) word[31:16] = 16'($urandom);
    if (idx == bpist_pkg::REG_SLEEP_ENABLE) word[15:1] = 15'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    case (idx)
      bpist_pkg::REG_DEBOUNCE:      cfg_now.debounce_ms       = word[15:0];
      bpist_pkg::REG_SHORT_MIN:     cfg_now.short_min_ms      = word[15:0];
      bpist_pkg::REG_SHORT_MAX:     cfg_now.short_max_ms      = word[15:0];
      bpist_pkg::REG_LONG_MIN:      cfg_now.long_min_ms       = word[15:0];
      bpist_pkg::REG_CHECK_INTRVL:  cfg_now.check_interval_ms = word[15:0];
      bpist_pkg::REG_SLEEP_TIMEOUT: cfg_now.sleep_timeout_ms  = word;
      bpist_pkg::REG_SLEEP_ENABLE:  cfg_now.sleep_enable      = word[0];
      default: ;
    endcase
    if (idx == REG_UNMAPPED) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clk);
    end else begin
      apb_read_check(idx);
    end
  endtask

  task automatic load_config(input logic [15:0] db, input logic [15:0] smin,
                             input logic [15:0] smax, input logic [15:0] lmin,
                             input logic [15:0] chk, input logic [31:0] tmo,
                             input logic en);
    write_reg(bpist_pkg::REG_DEBOUNCE, 32'(db));
    write_reg(bpist_pkg::REG_SHORT_MIN, 32'(smin));
    write_reg(bpist_pkg::REG_SHORT_MAX, 32'(smax));
    write_reg(bpist_pkg::REG_LONG_MIN, 32'(lmin));
    write_reg(bpist_pkg::REG_CHECK_INTRVL, 32'(chk));
    write_reg(bpist_pkg::REG_SLEEP_TIMEOUT, tmo);
    write_reg(bpist_pkg::REG_SLEEP_ENABLE, 32'(en));
  endtask

  // Offer one tick word, record its prediction on acceptance, then pace the burst
  task automatic offer(input bpist_pkg::tick_t t);
    in_valid          <= 1'b1;
    in_button_down    <= t.button_down;
    in_board_power_on <= t.board_power_on;
    in_link_connected <= t.link_connected;
    in_activity       <= t.activity;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed_results.push_back(timer_tick(t));
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 30);
      end
    end
  endtask

  task automatic hold_level(input logic btn, input logic pwr, input logic link,
                            input logic act, input int n);
    bpist_pkg::tick_t t;
    t = {btn, pwr, link, act};
    repeat (n) offer(t);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Button held or released for random spans, with short bounces and some noise words
  task automatic run_traffic(input int count, input int span);
    bpist_pkg::tick_t t;
    for (int i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        btn_now  = !btn_now;
        seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(1, span);
      end
      seg_left--;
      if ($urandom_range(0, 39) == 0) pwr_now = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 59) == 0) link_now = ($urandom_range(0, 3) == 0);
      t.button_down    = btn_now;
      t.board_power_on = pwr_now;
      t.link_connected = link_now;
      t.activity       = ($urandom_range(0, 29) == 0);
      if ($urandom_range(0, 19) == 0) t = bpist_pkg::tick_t'(4'($urandom));
      offer(t);
    end
    settle();
  endtask

  task automatic test_register_defaults();
    for (int i = 0; i < 7; i++) apb_read_check(3'(i));
    run_traffic(12, 5);
  endtask

  task automatic test_press_classes();
    load_config(16'd1, 16'd2, 16'd3, 16'd6, 16'd3, 32'd8, 1'b1);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    hold_level(1'b0, 1'b1, 1'b0, 1'b0, 2);
    // short press
    hold_level(1'b1, 1'b1, 1'b0, 1'b0, 3);
    hold_level(1'b0, 1'b1, 1'b0, 1'b0, 2);
    // length between the short and long ranges: no pulse
    hold_level(1'b1, 1'b0, 1'b0, 1'b0, 5);
    hold_level(1'b0, 1'b0, 1'b0, 1'b1, 2);
    // long press
    hold_level(1'b1, 1'b0, 1'b1, 1'b0, 7);
    hold_level(1'b0, 1'b0, 1'b1, 1'b0, 2);
    // bounce inside the debounce window
    hold_level(1'b1, 1'b0, 1'b0, 1'b0, 1);
    hold_level(1'b0, 1'b0, 1'b0, 1'b0, 1);
    settle();
  endtask

  task automatic test_sleep_watchdog();
    // zero interval checks every tick; request repeats while idle stays past the timeout
    load_config(16'd1, 16'd2, 16'd3, 16'd6, 16'd0, 32'd4, 1'b1);
    hold_level(1'b0, 1'b0, 1'b0, 1'b0, 6);
    hold_level(1'b0, 1'b0, 1'b0, 1'b1, 1);
    hold_level(1'b0, 1'b1, 1'b0, 1'b0, 2);
    hold_level(1'b0, 1'b0, 1'b1, 1'b0, 2);
    hold_level(1'b0, 1'b0, 1'b0, 1'b0, 5);
    settle();
    write_reg(bpist_pkg::REG_SLEEP_ENABLE, 32'd0);
    hold_level(1'b0, 1'b0, 1'b0, 1'b0, 3);
    settle();
  endtask

  task automatic test_random_traffic();
    drain_style = DRAIN_RANDOM;
    gaps_on     = 1'b1;
    load_config(16'd3, 16'd2, 16'd12, 16'd20, 16'd7, 32'd40, 1'b1);
    run_traffic(450, 30);

    // overlapping ranges, check on every tick, zero timeout
    drain_style = DRAIN_PATTERN;
    drain_mask  = 8'($urandom) | 8'h01;
    load_config(16'd0, 16'd5, 16'd25, 16'd10, 16'd0, 32'd0, 1'b1);
    run_traffic(350, 35);

    // no idling on either side, watchdog off
    drain_style = DRAIN_FREE;
    gaps_on     = 1'b0;
    load_config(16'd10, 16'd1, 16'd50, 16'd60, 16'd3, 32'd5, 1'b0);
    run_traffic(250, 80);

    drain_style = DRAIN_RANDOM;
    gaps_on     = 1'b1;
    load_config(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    run_traffic(100, 10);

    load_config(16'd1, 16'd3, 16'd3, 16'd0, 16'd1, 32'd1, 1'b1);
    run_traffic(350, 8);
  endtask

  task automatic test_backpressure();
    drain_style = DRAIN_FREE;
    gaps_on     = 1'b0;
    hold_off    = 150;
    run_traffic(200, 20);
  endtask

  initial begin
    in_valid          = 1'b0;
    in_button_down    = 1'b0;
    in_board_power_on = 1'b0;
    in_link_connected = 1'b0;
    in_activity       = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    mismatches        = 0;
    gaps_on           = 1'b0;
    burst_left        = 0;
    drain_style       = DRAIN_FREE;
    hold_off          = 0;
    drain_mask        = 8'hFF;
    rx_phase          = '0;
    btn_now           = 1'b0;
    pwr_now           = 1'b0;
    link_now          = 1'b0;
    seg_left          = 0;
    rst_n             = 1'b0;
    clear_timer();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_press_classes();
    test_sleep_watchdog();
    test_random_traffic();
    test_backpressure();

    settle();
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
